### rtl/msb_first_bit_reader_core_defines.svh
// Assertion macros for the MSB-first bit reader.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef MSB_FIRST_BIT_READER_CORE_DEFINES_SVH
`define MSB_FIRST_BIT_READER_CORE_DEFINES_SVH

// Property checked on every rising clock edge outside reset
`define MSBBR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Implication checked on every rising clock edge outside reset
`define MSBBR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/msbbr_pkg.sv
// Shared constants, types and helpers for the MSB-first bit reader.
// No dependencies; used by msbbr_shift_merge and msb_first_bit_reader_core.
package msbbr_pkg;

    // Byte store size and derived widths
    localparam int STORE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    // Input item kinds (s_tuser)
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Largest read length in bits
    localparam logic [5:0] MAX_BITS = 6'd32;

    // Control of the shared shift-merge unit
    typedef struct packed {
        logic       clr;  // start from an empty accumulator
        logic [3:0] sh;   // left shift, 0..8
        logic [7:0] ins;  // bits merged into the low end
    } merge_ctl_t;

    // Mask of the low k bits of a byte, k = 0..8
    function automatic logic [7:0] low_mask(input logic [3:0] k);
        logic [7:0] m;
        m = 8'hff >> (4'd8 - k);
        return m;
    endfunction

endpackage

### rtl/msb_first_bit_reader_core.sv
// MSB-first bit reader: bytes are loaded into a 1024-entry store with load
// transfers (s_tuser = 0, no result, dropped once the store is full) and read
// transfers (s_tuser = 1) return 0..32 bits, first bit most significant, with an
// end-of-stream flag on m_tuser. A load is written in the cycle it is accepted.
// A read that the current byte already can serve goes through start, merge and
// done. Each byte fetched from the store adds an address-out step and then a
// step that merges the registered read data. The first fetch of a read is the
// exception: its address goes out in the start step, so it adds only the merge
// step. A read that ends on a whole byte adds a final step to see that no bits
// are left. An end of stream at the first fetch goes through start and done
// only. A 32-bit read from an empty current byte needs the most steps. The
// next transfer is accepted only once the reader is back in idle. The done
// state is held while the output register has a result m_tready has not taken.
// s_tready is high only while no read is in progress.
// Depends on msbbr_pkg, msbbr_shift_merge and the assertion macro header.
`include "msb_first_bit_reader_core_defines.svh"

module msb_first_bit_reader_core
    import msbbr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] data_byte, [13:8] read_len, [15:14] zero
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value
    output logic        m_tuser    // [0] error
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_FIRST = 3'd3;
    localparam logic [2:0] S_BODY  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Where a byte fetch returns to
    localparam logic [1:0] R_FIRST = 2'd0;
    localparam logic [1:0] R_WHOLE = 2'd1;
    localparam logic [1:0] R_TAIL  = 2'd2;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       ret_reg, ret_next;
    logic [CNT_W-1:0] sc_reg, sc_next;     // bytes loaded
    logic [CNT_W-1:0] rp_reg, rp_next;     // next byte to fetch
    logic [7:0]       cur_reg, cur_next;   // current byte
    logic [3:0]       bl_reg, bl_next;     // unread low bits of current byte
    logic [5:0]       n_reg, n_next;       // bits still to read
    logic [31:0]      val_reg, val_next;
    logic             err_reg, err_next;
    logic [7:0]       mem_q_reg;
    logic             m_tvalid_reg;
    logic [31:0]      m_tdata_reg;
    logic             m_tuser_reg;

    logic [7:0]       store [STORE_DEPTH];
    logic             wr_en;
    logic             out_free;
    logic             have_byte;
    logic [5:0]       s_num;
    merge_ctl_t       mctl;
    logic [31:0]      merge_out;

    assign s_tready  = (state_reg == S_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign have_byte = (rp_reg < sc_reg);
    assign s_num     = s_tdata[13:8];
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // Shared shift-merge unit
    msbbr_shift_merge u_merge (
        .val_in  (val_reg),
        .ctl     (mctl),
        .val_out (merge_out)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        sc_next    = sc_reg;
        rp_next    = rp_reg;
        cur_next   = cur_reg;
        bl_next    = bl_reg;
        n_next     = n_reg;
        val_next   = val_reg;
        err_next   = err_reg;
        wr_en      = 1'b0;
        mctl       = '{clr: 1'b0, sh: 4'd0, ins: 8'd0};
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == KIND_READ) begin
                        n_next     = s_num[5] ? MAX_BITS : s_num;
                        val_next   = 32'd0;
                        err_next   = 1'b0;
                        state_next = S_START;
                    end else if (sc_reg < CNT_W'(STORE_DEPTH)) begin
                        wr_en   = 1'b1;
                        sc_next = sc_reg + CNT_W'(1);
                    end
                end
            end
            S_START: begin
                if (bl_reg != 4'd0) begin
                    state_next = S_FIRST;
                end else if (have_byte) begin
                    rp_next    = rp_reg + CNT_W'(1);
                    ret_next   = R_FIRST;
                    state_next = S_WAIT;
                end else begin
                    // end of stream before anything was read
                    val_next   = 32'd0;
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_WAIT: begin
                cur_next = mem_q_reg;
                unique case (ret_reg)
                    R_FIRST: begin
                        bl_next    = 4'd8;
                        state_next = S_FIRST;
                    end
                    R_WHOLE: begin
                        mctl       = '{clr: 1'b0, sh: 4'd8, ins: mem_q_reg};
                        val_next   = merge_out;
                        n_next     = n_reg - 6'd8;
                        state_next = S_BODY;
                    end
                    R_TAIL: begin
                        mctl       = '{clr: 1'b0, sh: n_reg[3:0],
                                       ins: 8'(mem_q_reg >> (4'd8 - n_reg[3:0]))};
                        val_next   = merge_out;
                        bl_next    = 4'd8 - n_reg[3:0];
                        state_next = S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_FIRST: begin
                if (n_reg <= {2'd0, bl_reg}) begin
                    // read fits in the current byte
                    mctl       = '{clr: 1'b1, sh: 4'd0,
                                   ins: 8'(cur_reg >> (bl_reg - n_reg[3:0]))
                                        & low_mask(n_reg[3:0])};
                    val_next   = merge_out;
                    bl_next    = bl_reg - n_reg[3:0];
                    state_next = S_DONE;
                end else begin
                    // take the rest of the current byte
                    mctl       = '{clr: 1'b1, sh: 4'd0, ins: cur_reg & low_mask(bl_reg)};
                    val_next   = merge_out;
                    n_next     = n_reg - {2'd0, bl_reg};
                    bl_next    = 4'd0;
                    state_next = S_BODY;
                end
            end
            S_BODY: begin
                if (n_reg >= 6'd8) begin
                    if (have_byte) begin
                        rp_next    = rp_reg + CNT_W'(1);
                        ret_next   = R_WHOLE;
                        state_next = S_WAIT;
                    end else begin
                        // stale byte still shifted in on end of stream
                        mctl       = '{clr: 1'b0, sh: 4'd8, ins: cur_reg};
                        val_next   = merge_out;
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end
                end else if (n_reg != 6'd0) begin
                    if (have_byte) begin
                        rp_next    = rp_reg + CNT_W'(1);
                        ret_next   = R_TAIL;
                        state_next = S_WAIT;
                    end else begin
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= R_FIRST;
            sc_reg    <= '0;
            rp_reg    <= '0;
            cur_reg   <= 8'd0;
            bl_reg    <= 4'd0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            sc_reg    <= sc_next;
            rp_reg    <= rp_next;
            cur_reg   <= cur_next;
            bl_reg    <= bl_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        val_reg <= val_next;
        err_reg <= err_next;
    end

    // Byte store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[sc_reg[ADDR_W-1:0]] <= s_tdata[7:0];
        end
        mem_q_reg <= store[rp_reg[ADDR_W-1:0]];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_DONE && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_DONE && out_free) begin
            m_tdata_reg <= val_reg;
            m_tuser_reg <= err_reg;
        end
    end

    // Checks
    `MSBBR_ASSERT(a_rp_le_sc, rp_reg <= sc_reg, "read position passed stored count")
    `MSBBR_ASSERT(a_bl_range, bl_reg <= 4'd8, "bits left out of range")
    `MSBBR_ASSERT_IMPL(a_out_done, $rose(m_tvalid_reg), $past(state_reg == S_DONE), "stray result")

endmodule

### rtl/msbbr_shift_merge.sv
// Shared shift-merge unit: shifts the value accumulator left and ORs in new bits.
// Depends on msbbr_pkg (merge_ctl_t).
module msbbr_shift_merge
    import msbbr_pkg::*;
(
    input  logic [31:0] val_in,
    input  merge_ctl_t  ctl,
    output logic [31:0] val_out
);

    logic [31:0] base;

    // Accumulator, or zero when cleared, shifted by up to one byte, new bits in the low end
    always_comb begin
        base    = ctl.clr ? 32'd0 : val_in;
        val_out = 32'(base << ctl.sh) | {24'd0, ctl.ins};
    end

endmodule

### test/msb_first_bit_reader_core_tb.sv
// Self-checking testbench for msb_first_bit_reader_core: byte loads and MSB-first bit reads
// go in on the s_ stream, and each read's value and end-of-stream flag are checked on m_.
// Depends on msbbr_pkg and the RTL of the block; nothing else.
`timescale 1ns / 100ps

module msb_first_bit_reader_core_tb;
    import msbbr_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 1000;

    typedef struct {
        logic [31:0] value;
        logic        error;
    } read_result_t;

    // Bit reader predictor plus the queue of read results still owed by the block
    class bit_reader_scoreboard;
        logic [7:0]   byte_mem [STORE_DEPTH];
        int unsigned  loaded;
        int unsigned  next_pos;
        int unsigned  left;
        logic [7:0]   cur;
        read_result_t pending_reads [$];
        int           errors;

        function new();
            loaded   = 0;
            next_pos = 0;
            left     = 0;
            cur      = 8'h00;
            errors   = 0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        // Unread bits still reachable: rest of the current byte plus stored bytes
        function int unsigned avail_bits();
            return (loaded - next_pos) * 8 + left;
        endfunction

        // Pull the next stored byte once the current one is used up; 0 on end of stream
        function bit fetch_byte();
            if (left != 0)
                return 1'b1;
            if (next_pos < loaded) begin
                cur = byte_mem[next_pos];
                next_pos++;
                left = 8;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Accepted input transfer: loads fill the store, reads queue their expected result
        function void note_transfer(logic kind, logic [7:0] data, logic [5:0] nbits);
            int unsigned  n;
            logic [31:0]  val;
            bit           ok;
            read_result_t r;
            if (kind == KIND_LOAD) begin
                if (loaded < STORE_DEPTH) begin
                    byte_mem[loaded] = data;
                    loaded++;
                end
                return;
            end
            n   = (nbits > MAX_BITS) ? MAX_BITS : nbits;
            val = 32'h0;
            ok  = fetch_byte();
            if (ok) begin
                if (n <= left) begin
                    left -= n;
                    val = (32'(cur) >> left) & (32'hff >> (8 - n));
                end else begin
                    // rest of current byte, then whole bytes, then top bits of the last
                    val = 32'(cur) & (32'hff >> (8 - left));
                    n -= left;
                    left = 0;
                    while (ok && n >= 8) begin
                        ok = fetch_byte();
                        // stale byte still shifted in when the fetch fails
                        val = (val << 8) | 32'(cur);
                        n -= 8;
                        left = 0;
                    end
                    if (ok && n > 0) begin
                        ok = fetch_byte();
                        if (ok) begin
                            val = (val << n) | (32'(cur) >> (8 - n));
                            left = 8 - n;
                        end
                    end
                end
            end
            r.value = val;
            r.error = !ok;
            pending_reads.push_back(r);
        endfunction

        // Result transfer against the oldest expected read
        task check_result(logic [31:0] value, logic error);
            read_result_t r;
            if (pending_reads.size() == 0) begin
                report($sformatf("result value %08h error %0b with no read pending",
                                 value, error));
            end else begin
                r = pending_reads.pop_front();
                if (value !== r.value)
                    report($sformatf("value %08h, expected %08h", value, r.value));
                if (error !== r.error)
                    report($sformatf("error %0b, expected %0b", error, r.error));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'h0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    bit_reader_scoreboard sb;
    int tx_calm = 0;
    int rx_calm = 0;
    int cycles  = 0;

    msb_first_bit_reader_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Idle wait drawn before a transfer, with occasional stretches of no wait
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    // One input transfer; valid is lowered only when a gap is drawn
    task send_item(logic kind, logic [7:0] data, logic [5:0] nbits);
        int gap;
        gap = draw_wait(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, nbits, data};
        do @(posedge aclk); while (!s_tready);
        sb.note_transfer(kind, data, nbits);
    endtask

    task load_byte(logic [7:0] data);
        send_item(KIND_LOAD, data, 6'($urandom_range(0, 63)));
    endtask

    task read_bits(logic [5:0] nbits);
        send_item(KIND_READ, 8'($urandom_range(0, 255)), nbits);
    endtask

    // Hold off input until every read result is back
    task drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending_reads.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Read length: mostly within the loaded data, some oversized or past the end
    function automatic logic [5:0] pick_read_len();
        int unsigned lim;
        if ($urandom_range(0, 9) == 0)
            return 6'($urandom_range(0, 63));
        lim = (sb.avail_bits() < 32) ? sb.avail_bits() : 32;
        if (lim == 32 && $urandom_range(0, 7) == 0)
            return 6'($urandom_range(33, 63));
        return 6'($urandom_range(0, lim));
    endfunction

    // Result side: random stalls, every transfer checked
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = draw_wait(rx_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser);
        end
    end

    // Stimulus
    initial begin
        int items;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // end of stream at the first fetch, store still empty
        read_bits(6'd0);
        read_bits(6'd32);
        // extreme bytes and bit patterns
        load_byte(8'hff);
        load_byte(8'h00);
        load_byte(8'ha5);
        load_byte(8'h5a);
        load_byte(8'h80);
        load_byte(8'h01);
        read_bits(6'd0);    // fetches a byte, returns nothing
        read_bits(6'd1);
        read_bits(6'd7);
        read_bits(6'd8);
        read_bits(6'd63);   // oversized, taken as 32 bits
        // partial byte carried into the next read
        load_byte(8'h3c);
        load_byte(8'hc3);
        read_bits(6'd12);
        // end of stream in a whole-byte step
        read_bits(6'd20);
        // end of stream in the final partial step
        load_byte(8'h96);
        read_bits(6'd12);
        read_bits(6'd33);
        drain_results();

        // Random mix until RANDOM_ITEMS items have gone in and the store is full
        items = 0;
        while (items < RANDOM_ITEMS || sb.loaded < STORE_DEPTH) begin
            if (items == RANDOM_ITEMS / 2)
                drain_results();
            if (sb.loaded < STORE_DEPTH && $urandom_range(0, 9) < 7)
                load_byte(8'($urandom_range(0, 255)));
            else
                read_bits(pick_read_len());
            items++;
        end

        // store full: these loads are dropped
        repeat (6) load_byte(8'($urandom_range(0, 255)));
        // read the rest of the stream, then past its end
        while (sb.avail_bits() > 0)
            read_bits(pick_read_len());
        repeat (8) read_bits(6'($urandom_range(0, 63)));

        drain_results();
        repeat (40) @(posedge aclk);
        if (sb.pending_reads.size() != 0)
            sb.report($sformatf("%0d read results never arrived", sb.pending_reads.size()));
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
